### rtl/eme_pkg.sv
// shared types and constants for the modular exponentiation engine
`timescale 1ns / 1ps
package eme_pkg;
    localparam int VALUE_BITS = 32;
    localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_PUBKEY  = 2'd0;
    localparam opcode_t OP_ENCRYPT = 2'd1;
    localparam opcode_t OP_DECRYPT = 2'd2;
    localparam opcode_t OP_UNUSED  = 2'd3;
    localparam logic [1:0] REG_MODULUS   = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_PRIVKEY   = 2'd2;
    typedef struct packed {
        logic start;
        logic busy;
    } mul_ctrl_t;
endpackage

### rtl/eme_modmul.sv
// bit-serial modular multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module eme_modmul (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  eme_pkg::value_t  a,
    input  eme_pkg::value_t  b,
    input  eme_pkg::value_t  m,
    output logic             done,
    output eme_pkg::value_t  r
);
    import eme_pkg::*;

    value_t a_reg, b_reg, r_reg;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [VALUE_BITS:0] dbl, dbl_red, add, add_red;

    always_comb
    begin
        dbl = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
        add = dbl_red + {1'b0, a_reg};
        add_red = (add >= {1'b0, m}) ? add - {1'b0, m} : add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == BIT_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= BIT_CNT_W'(VALUE_BITS);
                a_reg <= a;
                b_reg <= b;
                r_reg <= '0;
            end
            else if (busy_reg)
            begin
                r_reg <= b_reg[VALUE_BITS-1] ? add_red[VALUE_BITS-1:0]
                                             : dbl_red[VALUE_BITS-1:0];
                b_reg <= {b_reg[VALUE_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == BIT_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign r = r_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("multiply started while busy");
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("bit count slip");
`endif
endmodule

### rtl/elgamal_modexp_engine.sv
// top level of the elgamal modular exponentiation engine
`timescale 1ns / 1ps
// usage:
// configuration: write modulus (0), generator (1), private_key (2) on
//   cfg_valid/cfg_ready/cfg_index/cfg_data while the engine is idle and
//   no input transaction is offered.
// input channel in_valid/in_stall carries opcode, message_or_second and
//   nonce_or_first; one transaction is worked on at a time.
// output channel out_valid/out_stall carries first_value, second_value.
// multiply and square steps run in the bit-serial multiplier, each square
//   followed by the bit decision; each exponentiation first reduces its
//   base by one multiply by one.
// encrypt runs three exponentiations, reducing m and one multiply; a
//   modulus below two or the unused opcode goes straight to the output.
// reset returns modulus 2, generator 1, private_key 0 and an empty engine.
// a stalled result holds in the output register while the next
//   transaction is worked on; that one waits until the register frees.
module elgamal_modexp_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  eme_pkg::value_t  cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  eme_pkg::opcode_t opcode,
    input  eme_pkg::value_t  message_or_second,
    input  eme_pkg::value_t  nonce_or_first,
    output logic             out_valid,
    input  logic             out_stall,
    output eme_pkg::value_t  first_value,
    output eme_pkg::value_t  second_value
);
    import eme_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_POW_INIT, S_POW_MUL, S_POW_SQ, S_POW_DONE,
        S_FINAL, S_OUT
    } state_t;

    // sequence of exponentiations per opcode
    typedef enum logic [2:0] {
        J_GX, J_YK, J_GK, J_MK, J_CX, J_INV, J_MD
    } job_t;

    state_t state_reg;
    job_t job_reg;
    value_t p_reg, g_reg, x_reg;
    opcode_t op_reg;
    value_t m_reg, k_reg;
    value_t acc_reg, base_reg, exp_reg, t_reg, c1_reg;
    value_t fv_reg, sv_reg;
    value_t out_first_reg, out_second_reg;
    logic out_valid_reg;
    logic reduced_reg;
    logic mul_start_reg;
    logic mul_start_next;
    logic mul_done;
    value_t mul_a, mul_b, mul_r;
    mul_ctrl_t ctrl;

    assign ctrl.start = mul_start_reg;
    assign ctrl.busy = (state_reg != S_IDLE) && (state_reg != S_OUT);

    eme_modmul u_mul (
        .clk(clk), .rst_n(rst_n), .start(ctrl.start),
        .a(mul_a), .b(mul_b), .m(p_reg), .done(mul_done), .r(mul_r)
    );

    // a value below 2*p after one conditional subtract is not guaranteed,
    // so bases are reduced by multiplying by one (result always below p)
    value_t one_mod;
    assign one_mod = (p_reg == VALUE_BITS'(1)) ? '0 : VALUE_BITS'(1);

    always_comb
    begin
        mul_a = base_reg;
        mul_b = base_reg;
        if (!reduced_reg)
        begin
            mul_a = one_mod;
            mul_b = base_reg;
        end
        else if (state_reg == S_POW_MUL || state_reg == S_FINAL || job_reg == J_MD)
        begin
            mul_a = acc_reg;
            mul_b = base_reg;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_POW_INIT: mul_start_next = 1'b1;
            S_POW_MUL:  mul_start_next = mul_done;
            S_POW_DONE: mul_start_next = (exp_reg != '0);
            S_FINAL:    mul_start_next = (job_reg == J_MK);
            default:    mul_start_next = 1'b0;
        endcase
    end

    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;
    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg <= J_GX;
            p_reg <= VALUE_BITS'(2);
            g_reg <= VALUE_BITS'(1);
            x_reg <= '0;
            out_valid_reg <= 1'b0;
            out_first_reg <= '0;
            out_second_reg <= '0;
            mul_start_reg <= 1'b0;
            reduced_reg <= 1'b0;
        end
        else
        begin
            mul_start_reg <= mul_start_next;
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
                out_first_reg <= fv_reg;
                out_second_reg <= sv_reg;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODULUS:   p_reg <= cfg_data;
                    REG_GENERATOR: g_reg <= cfg_data;
                    REG_PRIVKEY:   x_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        op_reg <= opcode;
                        m_reg <= message_or_second;
                        k_reg <= nonce_or_first;
                        fv_reg <= '0;
                        sv_reg <= '0;
                        if (p_reg < VALUE_BITS'(2) || opcode == OP_UNUSED)
                            state_reg <= S_OUT;
                        else
                        begin
                            state_reg <= S_POW_INIT;
                            if (opcode == OP_DECRYPT)
                            begin
                                job_reg <= J_CX;
                                base_reg <= nonce_or_first;
                                exp_reg <= x_reg;
                            end
                            else
                            begin
                                job_reg <= J_GX;
                                base_reg <= g_reg;
                                exp_reg <= x_reg;
                            end
                        end
                    end
                end
                S_POW_INIT:
                begin
                    // reduce base
                    acc_reg <= VALUE_BITS'(1);
                    reduced_reg <= 1'b0;
                    state_reg <= S_POW_SQ;
                end
                S_POW_MUL:
                begin
                    if (mul_done)
                    begin
                        acc_reg <= mul_r;
                        state_reg <= S_POW_SQ;
                    end
                end
                S_POW_SQ:
                begin
                    if (mul_done)
                    begin
                        if (job_reg == J_MD)
                        begin
                            t_reg <= mul_r;
                            state_reg <= S_FINAL;
                        end
                        else
                        begin
                            base_reg <= mul_r;
                            if (!reduced_reg)
                            begin
                                reduced_reg <= 1'b1;
                                acc_reg <= one_mod;
                            end
                            else
                                exp_reg <= exp_reg >> 1;
                            state_reg <= S_POW_DONE;
                        end
                    end
                end
                S_POW_DONE:
                begin
                    // decide next step on the current exponent bit
                    if (exp_reg == '0)
                    begin
                        t_reg <= acc_reg;
                        state_reg <= S_FINAL;
                    end
                    else if (exp_reg[0])
                        state_reg <= S_POW_MUL;
                    else
                        state_reg <= S_POW_SQ;
                end
                S_FINAL:
                begin
                    // chain to next job, or pass the result to the output
                    case (job_reg)
                        J_GX:
                        begin
                            if (op_reg == OP_PUBKEY)
                            begin
                                fv_reg <= t_reg;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                job_reg <= J_YK;
                                base_reg <= t_reg;
                                exp_reg <= k_reg;
                                state_reg <= S_POW_INIT;
                            end
                        end
                        J_YK:
                        begin
                            c1_reg <= t_reg;
                            job_reg <= J_GK;
                            base_reg <= g_reg;
                            exp_reg <= k_reg;
                            state_reg <= S_POW_INIT;
                        end
                        J_GK:
                        begin
                            fv_reg <= t_reg;
                            // m^1 reduces m, then multiply by shared key
                            job_reg <= J_MK;
                            base_reg <= m_reg;
                            exp_reg <= VALUE_BITS'(1);
                            state_reg <= S_POW_INIT;
                        end
                        J_MK:
                        begin
                            job_reg <= J_MD;
                            acc_reg <= t_reg;
                            base_reg <= c1_reg;
                            reduced_reg <= 1'b1;
                            state_reg <= S_POW_SQ;
                            exp_reg <= '0;
                        end
                        J_CX:
                        begin
                            job_reg <= J_INV;
                            base_reg <= t_reg;
                            exp_reg <= p_reg - VALUE_BITS'(2);
                            state_reg <= S_POW_INIT;
                        end
                        J_INV:
                        begin
                            c1_reg <= t_reg;
                            job_reg <= J_MK;
                            base_reg <= m_reg;
                            exp_reg <= VALUE_BITS'(1);
                            state_reg <= S_POW_INIT;
                        end
                        J_MD:
                        begin
                            if (op_reg == OP_ENCRYPT)
                                sv_reg <= t_reg;
                            else
                                fv_reg <= t_reg;
                            state_reg <= S_OUT;
                        end
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign first_value = out_first_reg;
    assign second_value = out_second_reg;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.busy |-> in_stall) else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(first_value)
        && $stable(second_value))) else $error("stalled result changed");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> (state_reg == S_IDLE || state_reg == S_OUT))
        else $error("configuration open while busy");
`endif
endmodule
